[hw/rtl/bellman_ford_shortest_paths_unit_defines.svh]
// Assertion macros shared by the unit's RTL files.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_UNIT_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define BFSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BFSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BFSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hw/rtl/bfsp_pkg.sv]
package bfsp_pkg;

    localparam int MAX_VERTICES  = 64;
    localparam int MAX_EDGES     = 256;

    localparam int VTX_W    = 6;
    localparam int WGT_W    = 16;
    localparam int DIST_W   = 32;
    localparam int VCNT_W   = 7;
    localparam int VIDX_W   = $clog2(MAX_VERTICES);
    localparam int EADDR_W  = $clog2(MAX_EDGES);
    localparam int ECNT_W   = $clog2(MAX_EDGES + 1);

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(64);

    localparam logic signed [DIST_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RUN   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_NEGCYC = 2'd2
    } t_status;

    typedef enum logic {
        REG_VERTEX_COUNT = 1'b0,
        REG_DIRECTED     = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD2,
        S_POST,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    typedef struct packed {
        logic [VTX_W-1:0]        src_v;
        logic [VTX_W-1:0]        dst_v;
        logic signed [WGT_W-1:0] weight;
    } t_edge;

    // Edge leaving the edge memory toward the relaxation stage.
    typedef struct packed {
        logic  valid;
        logic  check;
        t_edge ed;
    } t_scan_edge;

    // Commands from the sequencer to the distance store.
    typedef struct packed {
        logic             init;
        logic [VTX_W-1:0] src;
        logic             rd_en;
        logic [VTX_W-1:0] rd_addr;
    } t_dist_cmd;

    typedef struct packed {
        logic e_busy;
        logic changed;
    } t_relax_stat;

    // Vertex count in use: zero acts as one, large values clamp.
    function automatic logic [VCNT_W-1:0] active_count(input logic [VCNT_W-1:0] vc);
        logic [VCNT_W-1:0] res;
        res = vc;
        if (vc == '0) begin
            res = VCNT_W'(1);
        end else if (vc > VCNT_W'(MAX_VERTICES)) begin
            res = VCNT_W'(MAX_VERTICES);
        end
        return res;
    endfunction

endpackage

[hw/rtl/bfsp_edge_store.sv]
module bfsp_edge_store
    import bfsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_append,
    input  t_edge              i_append_edge,
    input  logic               i_clear,
    input  logic               i_rd_en,
    input  logic [EADDR_W-1:0] i_rd_addr,
    output t_edge              o_rd_edge,
    output logic [ECNT_W-1:0]  o_total
);

    t_edge             mem_edge [MAX_EDGES];
    t_edge             r_rd_edge;
    logic [ECNT_W-1:0] r_total;

    // append at the fill mark; caller guarantees room
    always_ff @(posedge i_clk) begin
        if (i_append) begin
            mem_edge[r_total[EADDR_W-1:0]] <= i_append_edge;
        end
        if (i_rd_en) begin
            r_rd_edge <= mem_edge[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_clear) begin
            r_total <= '0;
        end else if (i_append) begin
            r_total <= r_total + ECNT_W'(1);
        end
    end

    assign o_rd_edge = r_rd_edge;
    assign o_total   = r_total;

endmodule

[hw/rtl/bfsp_relax_unit.sv]
`include "bellman_ford_shortest_paths_unit_defines.svh"

module bfsp_relax_unit
    import bfsp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [VCNT_W-1:0]        i_n,
    input  t_dist_cmd                i_cmd,
    input  t_scan_edge               i_edge,
    output t_relax_stat              o_stat,
    output logic signed [DIST_W-1:0] o_rd_dist,
    output logic                     o_rd_reach
);

    logic signed [DIST_W-1:0] mem_dist [MAX_VERTICES];
    logic                     r_reach  [MAX_VERTICES];

    logic signed [DIST_W-1:0] r_qa, r_qb;
    logic                     r_qreach;

    logic                     r_e_valid, r_e_check;
    logic [VTX_W-1:0]         r_e_a, r_e_b;
    logic signed [WGT_W-1:0]  r_e_w;

    logic                     r_fw_valid;
    logic [VIDX_W-1:0]        r_fw_addr;
    logic signed [DIST_W-1:0] r_fw_data;

    logic                     r_changed;

    logic [VIDX_W-1:0]        w_addr_a, w_addr_b, w_ia, w_ib, w_wr_addr;
    logic                     w_rd_en;
    logic signed [DIST_W-1:0] w_dist_a, w_dist_b, w_cand, w_wr_data;
    logic signed [DIST_W:0]   w_sum;
    logic                     w_in_range, w_relax, w_we;

    // read addresses: emit readout takes port A, scan uses both
    assign w_addr_a = i_cmd.rd_en ? i_cmd.rd_addr[VIDX_W-1:0]
                                  : i_edge.ed.src_v[VIDX_W-1:0];
    assign w_addr_b = i_edge.ed.dst_v[VIDX_W-1:0];
    assign w_rd_en  = i_cmd.rd_en | i_edge.valid;

    assign w_ia = r_e_a[VIDX_W-1:0];
    assign w_ib = r_e_b[VIDX_W-1:0];

    // forward the write of the previous cycle, memory read missed it
    assign w_dist_a = (r_fw_valid && r_fw_addr == w_ia) ? r_fw_data : r_qa;
    assign w_dist_b = (r_fw_valid && r_fw_addr == w_ib) ? r_fw_data : r_qb;

    assign w_sum = {w_dist_a[DIST_W-1], w_dist_a}
                 + {{(DIST_W + 1 - WGT_W){r_e_w[WGT_W-1]}}, r_e_w};

    always_comb begin
        if (w_sum[DIST_W] != w_sum[DIST_W-1]) begin
            w_cand = w_sum[DIST_W] ? INT_MIN : INT_MAX;
        end else begin
            w_cand = w_sum[DIST_W-1:0];
        end
    end

    assign w_in_range = ({1'b0, r_e_a} < i_n) && ({1'b0, r_e_b} < i_n);
    assign w_relax    = r_e_valid && w_in_range && r_reach[w_ia]
                     && (!r_reach[w_ib] || (w_cand < w_dist_b));

    assign w_we      = i_cmd.init | w_relax;
    assign w_wr_addr = i_cmd.init ? i_cmd.src[VIDX_W-1:0] : w_ib;
    assign w_wr_data = i_cmd.init ? '0 : w_cand;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_dist[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_qa <= mem_dist[w_addr_a];
            r_qb <= mem_dist[w_addr_b];
        end
        if (i_cmd.rd_en) begin
            r_qreach <= r_reach[i_cmd.rd_addr[VIDX_W-1:0]];
        end
        r_e_check <= i_edge.check;
        r_e_a     <= i_edge.ed.src_v;
        r_e_b     <= i_edge.ed.dst_v;
        r_e_w     <= i_edge.ed.weight;
        r_fw_addr <= w_wr_addr;
        r_fw_data <= w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
            r_changed  <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_reach[i] <= 1'b0;
            end
        end else begin
            r_e_valid  <= i_edge.valid;
            r_fw_valid <= w_we;
            if (i_cmd.init) begin
                r_changed <= 1'b0;
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    r_reach[i] <= (i == int'(i_cmd.src[VIDX_W-1:0]));
                end
            end else if (w_relax) begin
                r_reach[w_ib] <= 1'b1;
                if (r_e_check) begin
                    r_changed <= 1'b1;
                end
            end
        end
    end

    assign o_stat.e_busy  = r_e_valid;
    assign o_stat.changed = r_changed;
    assign o_rd_dist      = r_qa;
    assign o_rd_reach     = r_qreach;

    `BFSP_ASSERT_IMP(a_init_no_relax, i_clk, i_rst_n, i_cmd.init, !w_relax, "init during relaxation")
    `BFSP_ASSERT_NXT(a_relax_marks, i_clk, i_rst_n, w_relax, r_reach[$past(w_ib)], "relaxed vertex not marked")

endmodule

[hw/rtl/bellman_ford_shortest_paths_unit.sv]
// Bellman-Ford shortest paths over a loaded edge table. Items on the slave stream carry a
// command in tuser: add edge (stored twice when the directed register is 0), run from a
// source, or clear the table; each add, clear or bad run gives one result item, a
// successful run gives one item per vertex in use (or one negative-cycle item), with
// tlast on the final one. A run sweeps the stored edge table once per pass for n passes,
// where n is the vertex count in use and the last pass is the check, then, if the check
// pass changed nothing, reports each vertex; the edge memory's single read port sets
// the scan pace at one edge per cycle, and the three stages (edge read, distance read,
// relax and write back) overlap across edges and passes. The distance memory is not
// cleared; reachability flags mark its valid entries. Write the configuration port only
// while no command is in progress.
`include "bellman_ford_shortest_paths_unit_defines.svh"

module bellman_ford_shortest_paths_unit
    import bfsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,     // 0 vertex_count, 1 directed
    input  logic [6:0]  i_cfg_data,
    // command items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [5:0] from_vertex, [11:6] to_vertex,
                                         // [27:12] weight, [31:28] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] op
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [5:0] vertex, [37:6] distance, [38] reachable,
                                         // [39] zero
    output logic [1:0]  o_m_axis_tuser,  // [1:0] status
    output logic        o_m_axis_tlast   // last
);

    // ---------------------------------------------------------------- configuration
    logic [VCNT_W-1:0] r_vcount;
    logic              r_directed;
    logic [VCNT_W-1:0] w_n;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount   <= VCOUNT_RESET;
            r_directed <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_VERTEX_COUNT: r_vcount   <= i_cfg_data;
                REG_DIRECTED:     r_directed <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign w_n = active_count(r_vcount);

    // ---------------------------------------------------------------- input fields
    t_op                     w_op;
    logic [VTX_W-1:0]        w_in_a, w_in_b;
    logic signed [WGT_W-1:0] w_in_w;

    assign w_op   = t_op'(i_s_axis_tuser);
    assign w_in_a = i_s_axis_tdata[5:0];
    assign w_in_b = i_s_axis_tdata[11:6];
    assign w_in_w = i_s_axis_tdata[27:12];

    // ---------------------------------------------------------------- state
    t_state                  r_state, n_state;
    logic [EADDR_W-1:0]      r_k, n_k;         // next edge to read
    logic [VCNT_W-1:0]       r_pass, n_pass;   // 1..n, the last pass is the check
    logic                    r_issue, n_issue; // edge reads still to issue
    logic                    r_d_valid, n_d_valid;
    logic                    r_d_check, n_d_check;
    logic [VTX_W-1:0]        r_vi, n_vi;       // vertex being reported
    t_status                 r_status, n_status;
    logic [VTX_W-1:0]        r_in_a, r_in_b;   // held for the reverse edge copy
    logic signed [WGT_W-1:0] r_in_w;

    // output register
    logic                     r_o_valid;
    logic [VTX_W-1:0]         r_o_vertex;
    logic signed [DIST_W-1:0] r_o_dist;
    logic                     r_o_reach;
    t_status                  r_o_status;
    logic                     r_o_last;

    logic                     w_load;
    logic [VTX_W-1:0]         w_ld_vertex;
    logic signed [DIST_W-1:0] w_ld_dist;
    logic                     w_ld_reach;
    t_status                  w_ld_status;
    logic                     w_ld_last;
    logic                     w_slot_free;

    // submodule links
    logic                     w_append, w_clear, w_rd_en;
    t_edge                    w_append_edge, w_rd_edge;
    logic [ECNT_W-1:0]        w_total;
    t_dist_cmd                w_cmd;
    t_scan_edge               w_scan_edge;
    t_relax_stat              w_stat;
    logic signed [DIST_W-1:0] w_rd_dist;
    logic                     w_rd_reach;

    logic w_room, w_add_ok, w_last_edge, w_last_vertex, w_k_in_table;

    assign w_slot_free   = !r_o_valid || i_m_axis_tready;
    assign w_room        = r_directed ? (w_total < ECNT_W'(MAX_EDGES))
                                      : (w_total <= ECNT_W'(MAX_EDGES - 2));
    assign w_add_ok      = ({1'b0, w_in_a} < w_n) && ({1'b0, w_in_b} < w_n) && w_room;
    assign w_last_edge   = ({1'b0, r_k} + ECNT_W'(1)) == w_total;
    assign w_k_in_table  = {1'b0, r_k} < w_total;
    assign w_last_vertex = ({1'b0, r_vi} + VCNT_W'(1)) == w_n;

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_pass        = r_pass;
        n_issue       = r_issue;
        n_d_valid     = 1'b0;
        n_d_check     = 1'b0;
        n_vi          = r_vi;
        n_status      = r_status;
        w_append      = 1'b0;
        w_append_edge = '{src_v: w_in_a, dst_v: w_in_b, weight: w_in_w};
        w_clear       = 1'b0;
        w_rd_en       = 1'b0;
        w_cmd         = '0;
        w_load        = 1'b0;
        w_ld_vertex   = '0;
        w_ld_dist     = '0;
        w_ld_reach    = 1'b0;
        w_ld_status   = r_status;
        w_ld_last     = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    case (w_op)
                        OP_ADD: begin
                            if (w_add_ok) begin
                                w_append = 1'b1;
                                n_status = ST_OK;
                                n_state  = r_directed ? S_POST : S_ADD2;
                            end else begin
                                n_status = ST_REJECT;
                                n_state  = S_POST;
                            end
                        end
                        OP_CLEAR: begin
                            w_clear  = 1'b1;
                            n_status = ST_OK;
                            n_state  = S_POST;
                        end
                        OP_RUN: begin
                            if ({1'b0, w_in_a} < w_n) begin
                                // seed the source, then sweep the table pass by pass
                                w_cmd.init = 1'b1;
                                w_cmd.src  = w_in_a;
                                n_k        = '0;
                                n_pass     = VCNT_W'(1);
                                n_issue    = (w_total != '0);
                                n_state    = S_SCAN;
                            end else begin
                                n_status = ST_REJECT;
                                n_state  = S_POST;
                            end
                        end
                        default: ;   // unused op: drop the item
                    endcase
                end
            end
            S_ADD2: begin
                // reverse copy of an undirected edge
                w_append      = 1'b1;
                w_append_edge = '{src_v: r_in_b, dst_v: r_in_a, weight: r_in_w};
                n_state       = S_POST;
            end
            S_POST: begin
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    w_rd_en   = 1'b1;
                    n_d_valid = 1'b1;
                    n_d_check = (r_pass == w_n);
                    if (w_last_edge) begin
                        n_k = '0;
                        if (r_pass == w_n) begin
                            n_issue = 1'b0;
                        end else begin
                            n_pass = r_pass + VCNT_W'(1);
                        end
                    end else begin
                        n_k = r_k + EADDR_W'(1);
                    end
                end else if (!r_d_valid && !w_stat.e_busy) begin
                    // pipeline drained: the check pass verdict is final
                    if (w_stat.changed) begin
                        n_status = ST_NEGCYC;
                        n_state  = S_POST;
                    end else begin
                        n_vi    = '0;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                w_cmd.rd_en   = 1'b1;
                w_cmd.rd_addr = r_vi;
                n_state       = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (w_slot_free) begin
                    w_load      = 1'b1;
                    w_ld_vertex = r_vi;
                    w_ld_dist   = w_rd_reach ? w_rd_dist : INT_MAX;
                    w_ld_reach  = w_rd_reach;
                    w_ld_status = ST_OK;
                    w_ld_last   = w_last_vertex;
                    if (w_last_vertex) begin
                        n_state = S_IDLE;
                    end else begin
                        n_vi    = r_vi + VTX_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_d_valid <= n_d_valid;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload and counters: no reset, qualified by the control state above
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_pass    <= n_pass;
        r_d_check <= n_d_check;
        r_vi      <= n_vi;
        r_status  <= n_status;
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_a <= w_in_a;
            r_in_b <= w_in_b;
            r_in_w <= w_in_w;
        end
        if (w_load) begin
            r_o_vertex <= w_ld_vertex;
            r_o_dist   <= w_ld_dist;
            r_o_reach  <= w_ld_reach;
            r_o_status <= w_ld_status;
            r_o_last   <= w_ld_last;
        end
    end

    // ---------------------------------------------------------------- datapath
    bfsp_edge_store u_edge_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_append      (w_append),
        .i_append_edge (w_append_edge),
        .i_clear       (w_clear),
        .i_rd_en       (w_rd_en),
        .i_rd_addr     (r_k),
        .o_rd_edge     (w_rd_edge),
        .o_total       (w_total)
    );

    assign w_scan_edge.valid = r_d_valid;
    assign w_scan_edge.check = r_d_check;
    assign w_scan_edge.ed    = w_rd_edge;

    bfsp_relax_unit u_relax (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n        (w_n),
        .i_cmd      (w_cmd),
        .i_edge     (w_scan_edge),
        .o_stat     (w_stat),
        .o_rd_dist  (w_rd_dist),
        .o_rd_reach (w_rd_reach)
    );

    // ---------------------------------------------------------------- outputs
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {1'b0, r_o_reach, r_o_dist, r_o_vertex};
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tlast  = r_o_last;

    logic w_enter_emit, w_iss_ok, w_no_cycle;
    assign w_enter_emit = (r_state == S_SCAN) && (n_state == S_EMIT_RD);
    assign w_iss_ok     = (r_state == S_SCAN) && w_k_in_table;
    assign w_no_cycle   = !w_stat.changed;

    `BFSP_ASSERT_IMP(a_issue_in_table, i_clk, i_rst_n, r_issue, w_iss_ok, "edge read past fill")
    `BFSP_ASSERT_IMP(a_emit_no_cycle, i_clk, i_rst_n, w_enter_emit, w_no_cycle, "emit on cycle")
    `BFSP_ASSERT_IMP(a_load_slot_free, i_clk, i_rst_n, w_load, w_slot_free, "result overwritten")

endmodule

[dv/bellman_ford_shortest_paths_unit_tb.sv]
module bellman_ford_shortest_paths_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfsp_pkg::*;

    localparam int IDLE_PCT       = 27;
    localparam int RANDOM_ITEMS   = 60;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One result item as seen on the master stream.
    typedef struct {
        logic [VTX_W-1:0]         vertex;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic [1:0]               status;
        logic                     last;
    } t_report;

    // Shortest-path predictor plus the queue of result items it expects.
    class route_tracker;
        logic [VCNT_W-1:0]        vcount;
        bit                       directed;
        t_edge                    edges [MAX_EDGES];
        int unsigned              edge_cnt;
        logic signed [DIST_W-1:0] dist_val [MAX_VERTICES];
        bit                       reach [MAX_VERTICES];
        t_report                  expected_reports [$];
        int                       mismatches;

        function new();
            vcount   = VCOUNT_RESET;
            directed = 1'b1;
            edge_cnt = 0;
            mismatches = 0;
            foreach (dist_val[i]) begin
                dist_val[i] = '0;
                reach[i]    = 1'b0;
            end
        endfunction

        function void write_reg(logic idx, logic [VCNT_W-1:0] val);
            if (idx == REG_VERTEX_COUNT) begin
                vcount = val;
            end else begin
                directed = val[0];
            end
        endfunction

        // Zero acts as one vertex, anything past the array size clamps.
        function int unsigned vertices_in_use();
            if (vcount == 0) return 1;
            if (vcount > MAX_VERTICES) return MAX_VERTICES;
            return vcount;
        endfunction

        function logic signed [DIST_W-1:0] clamp_sum(logic signed [DIST_W-1:0] d,
                                                     logic signed [WGT_W-1:0] w);
            longint s;
            s = longint'(d) + longint'(w);
            if (s > longint'(INT_MAX)) return INT_MAX;
            if (s < longint'(INT_MIN)) return INT_MIN;
            return s[DIST_W-1:0];
        endfunction

        // One in-place pass over the stored edges; skip edges naming vertices not in use.
        function bit relax_all_edges(int unsigned n);
            bit                       changed;
            logic signed [DIST_W-1:0] cand;
            t_edge                    e;
            changed = 1'b0;
            for (int k = 0; k < edge_cnt; k++) begin
                e = edges[k];
                if (e.src_v >= n || e.dst_v >= n || !reach[e.src_v]) continue;
                cand = clamp_sum(dist_val[e.src_v], e.weight);
                if (!reach[e.dst_v] || cand < dist_val[e.dst_v]) begin
                    dist_val[e.dst_v] = cand;
                    reach[e.dst_v]    = 1'b1;
                    changed = 1'b1;
                end
            end
            return changed;
        endfunction

        function void push_report(int unsigned v, logic signed [DIST_W-1:0] d, bit r,
                                  logic [1:0] st, bit lst);
            t_report rep;
            rep.vertex    = v[VTX_W-1:0];
            rep.distance  = d;
            rep.reachable = r;
            rep.status    = st;
            rep.last      = lst;
            expected_reports = {expected_reports, rep};
        endfunction

        function void note_command(logic [1:0] op, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                                   logic [WGT_W-1:0] w);
            int unsigned n;
            int unsigned need;
            n = vertices_in_use();
            case (op)
                OP_ADD: begin
                    need = directed ? 1 : 2;
                    if (a >= n || b >= n || MAX_EDGES - edge_cnt < need) begin
                        push_report(0, '0, 1'b0, ST_REJECT, 1'b1);
                    end else begin
                        edges[edge_cnt] = {a, b, w};
                        edge_cnt++;
                        if (!directed) begin
                            edges[edge_cnt] = {b, a, w};
                            edge_cnt++;
                        end
                        push_report(0, '0, 1'b0, ST_OK, 1'b1);
                    end
                end
                OP_CLEAR: begin
                    edge_cnt = 0;
                    push_report(0, '0, 1'b0, ST_OK, 1'b1);
                end
                OP_RUN: begin
                    if (a >= n) begin
                        push_report(0, '0, 1'b0, ST_REJECT, 1'b1);
                    end else begin
                        foreach (reach[i]) reach[i] = 1'b0;
                        dist_val[a] = '0;
                        reach[a]    = 1'b1;
                        repeat (n - 1) void'(relax_all_edges(n));
                        if (relax_all_edges(n)) begin
                            push_report(0, '0, 1'b0, ST_NEGCYC, 1'b1);
                        end else begin
                            for (int unsigned v = 0; v < n; v++) begin
                                push_report(v, reach[v] ? dist_val[v] : INT_MAX, reach[v],
                                            ST_OK, v == n - 1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_report got);
            t_report want;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: v %0d dist %0d reach %0d status %0d last %0d",
                             got.vertex, got.distance, got.reachable, got.status, got.last);
                end
                return;
            end
            want = expected_reports.pop_front();
            if (got.vertex !== want.vertex || got.distance !== want.distance ||
                got.reachable !== want.reachable || got.status !== want.status ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("expected: v %0d dist %0d reach %0d status %0d last %0d",
                             want.vertex, want.distance, want.reachable, want.status,
                             want.last);
                    $display("actual:   v %0d dist %0d reach %0d status %0d last %0d",
                             got.vertex, got.distance, got.reachable, got.status, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index     = 1'b0;
    logic [6:0]  i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    route_tracker tracker = new();
    bit           steady = 1'b0;   // suppress idling on both sides
    int           items_sent = 0;
    int           idle_cycles = 0;

    bellman_ford_shortest_paths_unit dut (.*);

    initial forever #1 i_clk = ~i_clk;

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Result side: check each accepted item, then pick the next ready value.
    always @(posedge i_clk) begin : result_sink
        t_report got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.vertex    = o_m_axis_tdata[5:0];
                got.distance  = o_m_axis_tdata[37:6];
                got.reachable = o_m_axis_tdata[38];
                got.status    = o_m_axis_tuser;
                got.last      = o_m_axis_tlast;
                tracker.check_result(got);
            end
            i_m_axis_tready <= !take_break();
        end
    end

    // Count cycles in which no handshake of any kind completes.
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Hold valid high across back-to-back items; drop it only for a gap.
    task automatic send_command(input logic [1:0] op, input logic [5:0] from_v,
                                input logic [5:0] to_v, input logic [15:0] wgt);
        if (take_break()) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (take_break());
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, wgt, to_v, from_v};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_command(op, from_v, to_v, wgt);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // Stop sending until every expected result is back, then let the block settle.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [6:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [6:0] vc, input bit dir);
        write_reg(REG_VERTEX_COUNT, vc);
        write_reg(REG_DIRECTED, {6'($urandom), dir});
    endtask

    // Clear, load a random graph (mostly well formed), then run from a few sources.
    task automatic run_scenario(input logic [6:0] vc, input bit dir);
        int unsigned n;
        int unsigned pick;
        int unsigned wpick;
        logic [5:0]  a;
        logic [5:0]  b;
        logic [5:0]  t;
        logic [15:0] w;
        n = (vc == 0) ? 1 : ((vc > MAX_VERTICES) ? MAX_VERTICES : vc);
        configure(vc, dir);
        send_command(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
        repeat ($urandom_range(1, (n < 6) ? 6 : ((n > 24) ? 48 : 2 * n))) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_command(OP_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom));
            end else if (pick < 14) begin
                send_command(OP_ADD, 6'($urandom), 6'($urandom), 16'($urandom));
            end else begin
                a = 6'($urandom_range(n - 1));
                b = 6'($urandom_range(n - 1));
                // favor forward edges so negative weights rarely close a cycle
                if (dir && pick < 70 && a > b) begin
                    t = a;
                    a = b;
                    b = t;
                end
                wpick = $urandom_range(99);
                if (wpick < (dir ? 15 : 5)) begin
                    w = 16'($urandom);
                end else if (dir && wpick < 45) begin
                    w = 16'(-int'($urandom_range(1, 50)));
                end else begin
                    w = 16'($urandom_range(0, 100));
                end
                send_command(OP_ADD, a, b, w);
            end
        end
        repeat ($urandom_range(1, 3)) begin
            a = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
            send_command(OP_RUN, a, 6'($urandom), 16'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [6:0] extremes [4];
        logic [6:0] vc;
        int         scen;
        extremes = '{7'd0, 7'd1, 7'd64, 7'd127};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes, rejections, cycles, unused op.
        write_reg(REG_VERTEX_COUNT, 7'd4);
        send_command(OP_RUN,    6'd0,  6'd0,  16'h0000);   // empty table
        send_command(OP_ADD,    6'd0,  6'd1,  16'h7FFF);
        send_command(OP_ADD,    6'd1,  6'd2,  16'h8000);
        send_command(OP_ADD,    6'd0,  6'd3,  16'h0000);
        send_command(OP_ADD,    6'd4,  6'd0,  16'h0001);   // start out of range
        send_command(OP_ADD,    6'd0,  6'd63, 16'h0001);   // end out of range
        send_command(OP_RUN,    6'd1,  6'd0,  16'h0000);
        send_command(OP_RUN,    6'd4,  6'd0,  16'h0000);   // bad source
        send_command(OP_UNUSED, 6'd63, 6'd63, 16'hFFFF);
        send_command(OP_ADD,    6'd3,  6'd3,  16'hFFFF);   // negative self-loop
        send_command(OP_RUN,    6'd0,  6'd0,  16'h0000);
        send_command(OP_CLEAR,  6'd63, 6'd63, 16'hFFFF);
        send_command(OP_RUN,    6'd0,  6'd0,  16'h0000);
        write_reg(REG_DIRECTED, 7'd0);
        send_command(OP_ADD,    6'd2,  6'd2,  16'd5);      // undirected self-loop
        send_command(OP_ADD,    6'd0,  6'd1,  16'd7);
        send_command(OP_ADD,    6'd1,  6'd2,  16'd3);
        send_command(OP_RUN,    6'd1,  6'd0,  16'h0000);
        send_command(OP_ADD,    6'd1,  6'd3,  16'hFFFD);   // negative both ways
        send_command(OP_RUN,    6'd0,  6'd0,  16'h0000);
        write_reg(REG_DIRECTED, 7'd1);
        write_reg(REG_VERTEX_COUNT, 7'd64);
        send_command(OP_CLEAR,  6'd0,  6'd0,  16'h0000);
        send_command(OP_ADD,    6'd10, 6'd50, 16'd100);
        send_command(OP_ADD,    6'd0,  6'd10, 16'd1);
        send_command(OP_RUN,    6'd0,  6'd0,  16'h0000);   // report every vertex
        write_reg(REG_VERTEX_COUNT, 7'd12);                 // leave a stale edge behind
        send_command(OP_RUN,    6'd0,  6'd0,  16'h0000);
        write_reg(REG_VERTEX_COUNT, 7'd0);
        send_command(OP_RUN,    6'd0,  6'd0,  16'h0000);

        // Random graphs; the second and third scenarios run with no idling at all.
        items_sent = 0;
        scen = 0;
        while (items_sent < RANDOM_ITEMS) begin
            steady = (scen == 1 || scen == 2);
            if ($urandom_range(9) == 0) begin
                vc = extremes[$urandom_range(3)];
            end else begin
                vc = 7'($urandom_range(2, 12));
            end
            run_scenario(vc, 1'($urandom_range(1)));
            scen++;
        end
        steady = 1'b0;

        drain();
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
